### sv/tridiagonal_thomas_solver_macros.svh
// Assertion macros for the tridiagonal solver.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
// Generic implication check on the rising clock edge, off during reset.
`define TTS_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);
// Generic next-cycle implication check.
`define TTS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/tts_pkg.sv
// Package of types and constants for the tridiagonal solver.
package tts_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int FIELD_WIDTH     = 32;
    localparam int INDEX_WIDTH     = 6;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] sub_diag;
        logic signed [FIELD_WIDTH-1:0] diag;
        logic signed [FIELD_WIDTH-1:0] super_diag;
        logic signed [FIELD_WIDTH-1:0] rhs;
        logic                          last_row;
    } row_in_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] solution;
        logic [INDEX_WIDTH-1:0]        row_index;
        logic                          final_res;
        logic                          singular;
    } sol_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_MUL,
        ST_SUB,
        ST_DIV_C,
        ST_DIV_D,
        ST_WR,
        ST_BK_RD,
        ST_BK_MUL,
        ST_BK_OUT
    } state_t;

endpackage

### sv/tts_ram.sv
// Generic single-port synchronous RAM with registered read.
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### sv/tts_div.sv
// Iterative restoring divider giving a saturated fixed-point quotient.
module tts_div #(
    parameter int VALUE_WIDTH = tts_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = tts_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] num,
    input  logic signed [VALUE_WIDTH-1:0] den,
    output logic                          busy,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] quot
);

    localparam int DW = VALUE_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW:0] LIM_POS = (DW+1)'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

    logic [DW-1:0]          dvd_reg, dvd_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DW-1:0]          q_reg, q_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] nmag, dmag;
    logic [DW:0]            qext;

    always_comb
    begin
        nmag      = num[VALUE_WIDTH-1] ? VALUE_WIDTH'(-num) : VALUE_WIDTH'(num);
        dmag      = den[VALUE_WIDTH-1] ? VALUE_WIDTH'(-den) : VALUE_WIDTH'(den);
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[VALUE_WIDTH-1:0], dvd_reg[DW-1]};
        if (start)
        begin
            dvd_next  = DW'(nmag) << FRAC_BITS;
            rem_next  = '0;
            dvs_next  = dmag;
            q_next    = '0;
            cnt_next  = CW'(DW);
            neg_next  = num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1];
            zero_next = (den == '0);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // Saturate the magnitude back to the signed value range.
    always_comb
    begin
        qext = {1'b0, q_reg};
        if (zero_reg)
        begin
            quot = '0;
        end
        else if (neg_reg)
        begin
            if (qext > LIM_POS + 1'b1)
            begin
                quot = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            end
            else
            begin
                quot = VALUE_WIDTH'(-qext);
            end
        end
        else if (qext > LIM_POS)
        begin
            quot = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            quot = VALUE_WIDTH'(qext);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### sv/tts_mac.sv
// Registered fixed-point product followed by a saturating difference.
module tts_mac #(
    parameter int VALUE_WIDTH = tts_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = tts_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic signed [VALUE_WIDTH-1:0] mul_a,
    input  logic signed [VALUE_WIDTH-1:0] mul_b,
    input  logic signed [VALUE_WIDTH-1:0] minuend,
    output logic signed [VALUE_WIDTH-1:0] diff
);

    localparam int PW = 2 * VALUE_WIDTH;
    localparam logic [PW:0] LIM_POS = (PW+1)'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

    logic [VALUE_WIDTH-1:0] am, bm;
    logic [PW-1:0]          pm_reg;
    logic                   neg_reg;
    logic [PW:0]            sh;
    logic signed [VALUE_WIDTH-1:0] prod;
    logic signed [VALUE_WIDTH:0] dw;

    assign am = mul_a[VALUE_WIDTH-1] ? VALUE_WIDTH'(-mul_a) : VALUE_WIDTH'(mul_a);
    assign bm = mul_b[VALUE_WIDTH-1] ? VALUE_WIDTH'(-mul_b) : VALUE_WIDTH'(mul_b);

    always_ff @(posedge clk)
    begin
        pm_reg  <= PW'(am) * PW'(bm);
        neg_reg <= mul_a[VALUE_WIDTH-1] ^ mul_b[VALUE_WIDTH-1];
    end

    always_comb
    begin
        sh = {1'b0, pm_reg >> FRAC_BITS};
        if (neg_reg)
        begin
            if (sh > LIM_POS + 1'b1)
            begin
                prod = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            end
            else
            begin
                prod = VALUE_WIDTH'(-sh);
            end
        end
        else if (sh > LIM_POS)
        begin
            prod = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            prod = VALUE_WIDTH'(sh);
        end
        dw = (VALUE_WIDTH+1)'(minuend) - (VALUE_WIDTH+1)'(prod);
        if (dw[VALUE_WIDTH] != dw[VALUE_WIDTH-1])
        begin
            diff = dw[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                   : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            diff = dw[VALUE_WIDTH-1:0];
        end
    end

endmodule

### sv/tridiagonal_thomas_solver.sv
// Top level: Thomas algorithm tridiagonal solver with memory-held elimination state.
// Each row keeps busy high for two full passes through the one iterative divider.
// After the last row the first component is registered from the write state; the
// others follow, one per pass through the back-substitution read, multiply and output states.
// Rows enter only by a start while idle; the receiver cannot stall the strobed results.
// Reset (rst_n, asynchronous, active low) clears sequencer, row count and singular flag.
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS    = tts_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = tts_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = tts_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tts_pkg::row_in_t  row,
    output logic              busy,
    output logic              res_valid,
    output tts_pkg::sol_out_t res
);

`include "tridiagonal_thomas_solver_macros.svh"

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FW = tts_pkg::FIELD_WIDTH;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ROWS - 1);

    // Input fields are first saturated into the internal value range.
    function automatic logic signed [VALUE_WIDTH-1:0] sat_in(input logic signed [FW-1:0] v);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            w  = 64'(v);
            hi = 64'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
            lo = -hi - 64'sd1;
            if (w > hi)
            begin
                sat_in = VALUE_WIDTH'(hi);
            end
            else if (w < lo)
            begin
                sat_in = VALUE_WIDTH'(lo);
            end
            else
            begin
                sat_in = VALUE_WIDTH'(w);
            end
        end
    endfunction

    tts_pkg::state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          sing_reg, sing_next;
    logic          last_reg, last_next;
    logic signed [VALUE_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [VALUE_WIDTH-1:0] piv_reg, piv_next, numr_reg, numr_next;
    logic signed [VALUE_WIDTH-1:0] cq_reg, cq_next, x_reg, x_next;

    // Memory ports.
    logic                   we;
    logic [AW-1:0]          addr;
    logic [VALUE_WIDTH-1:0] sup_wdata, sup_rdata, rhs_rdata;

    // Shared arithmetic.
    logic signed [VALUE_WIDTH-1:0] m1_a, m1_b, m1_min, m1_diff;
    logic signed [VALUE_WIDTH-1:0] m2_diff;
    logic                          div_start, div_busy, div_done;
    logic signed [VALUE_WIDTH-1:0] div_num, div_q;

    logic                          out_v_reg, out_v_next;
    tts_pkg::sol_out_t             out_reg, out_next;

    tts_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ROWS)) u_sup_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(sup_wdata), .rdata(sup_rdata)
    );

    tts_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ROWS)) u_rhs_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(div_q), .rdata(rhs_rdata)
    );

    // The first unit forms a*c' against b, and during back substitution c'*x against d'.
    tts_mac #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac_sup (
        .clk(clk), .mul_a(m1_a), .mul_b(m1_b), .minuend(m1_min),
        .diff(m1_diff)
    );

    // The second unit forms a*d' against the right-hand side.
    tts_mac #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac_rhs (
        .clk(clk), .mul_a(a_reg), .mul_b(rhs_rdata), .minuend(d_reg),
        .diff(m2_diff)
    );

    tts_div #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(piv_reg),
        .busy(div_busy), .done(div_done), .quot(div_q)
    );

    always_comb
    begin
        if (state_reg == tts_pkg::ST_BK_MUL || state_reg == tts_pkg::ST_BK_OUT
            || state_reg == tts_pkg::ST_BK_RD)
        begin
            m1_a   = sup_rdata;
            m1_b   = x_reg;
            m1_min = rhs_rdata;
        end
        else
        begin
            m1_a   = a_reg;
            m1_b   = sup_rdata;
            m1_min = b_reg;
        end
    end

    assign sup_wdata = last_reg ? '0 : cq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::ST_IDLE;
            idx_reg   <= '0;
            sing_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sing_reg  <= sing_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == tts_pkg::ST_IDLE)
        begin
            a_reg <= sat_in(row.sub_diag);
            b_reg <= sat_in(row.diag);
            c_reg <= sat_in(row.super_diag);
            d_reg <= sat_in(row.rhs);
        end
        last_reg <= last_next;
        piv_reg  <= piv_next;
        numr_reg <= numr_next;
        cq_reg   <= cq_next;
        x_reg    <= x_next;
        out_reg  <= out_next;
    end

    // Sequencer: forward elimination of one row, then back substitution when last.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sing_next  = sing_reg;
        last_next  = last_reg;
        piv_next   = piv_reg;
        numr_next  = numr_reg;
        cq_next    = cq_reg;
        x_next     = x_reg;
        out_v_next = 1'b0;
        out_next   = out_reg;
        we         = 1'b0;
        addr       = idx_reg;
        div_start  = 1'b0;
        div_num    = c_reg;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    last_next  = row.last_row || (idx_reg == LAST_IDX);
                    state_next = tts_pkg::ST_RD_PREV;
                end
            end
            tts_pkg::ST_RD_PREV:
            begin
                // Fetch the previous row's scaled entries.
                addr       = idx_reg - 1'b1;
                state_next = tts_pkg::ST_MUL;
            end
            tts_pkg::ST_MUL:
            begin
                addr       = idx_reg - 1'b1;
                state_next = tts_pkg::ST_SUB;
            end
            tts_pkg::ST_SUB:
            begin
                if (idx_reg == '0)
                begin
                    piv_next  = b_reg;
                    numr_next = d_reg;
                end
                else
                begin
                    piv_next  = m1_diff;
                    numr_next = m2_diff;
                end
                state_next = tts_pkg::ST_DIV_C;
            end
            tts_pkg::ST_DIV_C:
            begin
                if (piv_reg == '0)
                begin
                    sing_next = 1'b1;
                end
                div_num   = c_reg;
                div_start = !div_busy && !div_done;
                if (div_done)
                begin
                    cq_next    = div_q;
                    div_num    = numr_reg;
                    div_start  = 1'b1;
                    state_next = tts_pkg::ST_DIV_D;
                end
            end
            tts_pkg::ST_DIV_D:
            begin
                if (div_done)
                begin
                    state_next = tts_pkg::ST_WR;
                end
            end
            tts_pkg::ST_WR:
            begin
                // The divider holds the scaled right-hand side until it restarts.
                we = 1'b1;
                if (last_reg)
                begin
                    x_next                = div_q;
                    out_v_next            = 1'b1;
                    out_next.solution     = tts_pkg::FIELD_WIDTH'(div_q);
                    out_next.row_index    = tts_pkg::INDEX_WIDTH'(idx_reg);
                    out_next.final_res    = (idx_reg == '0);
                    out_next.singular     = sing_reg;
                    if (idx_reg == '0)
                    begin
                        sing_next  = 1'b0;
                        state_next = tts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = tts_pkg::ST_BK_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_BK_RD:
            begin
                state_next = tts_pkg::ST_BK_MUL;
            end
            tts_pkg::ST_BK_MUL:
            begin
                state_next = tts_pkg::ST_BK_OUT;
            end
            tts_pkg::ST_BK_OUT:
            begin
                x_next             = m1_diff;
                out_v_next         = 1'b1;
                out_next.solution  = tts_pkg::FIELD_WIDTH'(m1_diff);
                out_next.row_index = tts_pkg::INDEX_WIDTH'(idx_reg);
                out_next.final_res = (idx_reg == '0);
                out_next.singular  = sing_reg;
                if (idx_reg == '0)
                begin
                    sing_next  = 1'b0;
                    state_next = tts_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = tts_pkg::ST_BK_RD;
                end
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != tts_pkg::ST_IDLE);
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    // A result other than the final one is only ever produced while the solver works on a system.
    `TTS_ASSERT_IMP(a_res_busy, clk, rst_n, res_valid && !res.final_res, busy,
        "result transfer outside a solve")
    // The final transfer returns the solver to idle.
    `TTS_ASSERT_IMP(a_final_idle, clk, rst_n, res_valid && res.final_res, !busy,
        "solver still busy after final transfer")
    // The divider is never restarted during a division.
    `TTS_ASSERT_IMP(a_div_start, clk, rst_n, div_busy, !div_start,
        "divider restarted while busy")

endmodule
